// ----- src/fifo_handle_pool_allocator_top_defines.svh -----
// Assertion macros used by the checker file of the handle pool allocator.
// Depends on nothing; included by bare file name.
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FHPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fhpa assertion failed");

// next-cycle implication
`define FHPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fhpa assertion failed");

`endif

// ----- src/fhpa_pkg.sv -----
// Package for the handle pool allocator: codes, beat structs, control types.
// Depends on nothing.
package fhpa_pkg;

   localparam int HANDLE_W      = 8;
   localparam int HANDLE_SPACE  = 256;
   localparam int COUNT_W       = 9;
   localparam int POOL_SIZE_DEF = 256;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_TRY     = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NONE_FREE   = 2'd1,
      STATUS_NOT_IN_USE  = 2'd2,
      STATUS_EXHAUSTED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle_out;
      logic [1:0]          status;
      logic                reused;
   } rsp_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// ----- src/fhpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module fhpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/fhpa_ctrl.sv -----
// Controller state machine: accepts a request, sequences execute, strobes result.
// Depends on fhpa_pkg.
module fhpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output fhpa_pkg::cmd_type cmd
);
   import fhpa_pkg::*;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      busy      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy      = 1'b1;
            cmd.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

// ----- src/fhpa_datapath.sv -----
// Datapath: free-list FIFO pointers, in-use bitmap, fresh counter, result register.
// Depends on fhpa_pkg and fhpa_ram.
module fhpa_datapath #(
   parameter int POOL_SIZE = fhpa_pkg::POOL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fhpa_pkg::cmd_type cmd,
   input  fhpa_pkg::req_type req_data,
   output fhpa_pkg::rsp_type rsp_data
);
   import fhpa_pkg::*;

   localparam int POOL_CAP = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
   localparam logic [COUNT_W-1:0] CAP_VAL = COUNT_W'(POOL_CAP);

   req_type                 req_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic [HANDLE_W-1:0]     head_ff, head_in;
   logic [HANDLE_W-1:0]     tail_ff, tail_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      fresh_ff, fresh_in;
   logic [HANDLE_SPACE-1:0] in_use_ff, in_use_in;
   logic                    ram_we;
   logic [HANDLE_W-1:0]     ram_rdata;

   fhpa_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (HANDLE_SPACE)
   ) u_free_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (req_ff.handle_in),
      .re    (cmd.load),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         fresh_ff  <= '0;
         in_use_ff <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         fresh_ff  <= fresh_in;
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      fresh_in  = fresh_ff;
      in_use_in = in_use_ff;
      ram_we    = 1'b0;
      rsp_in    = '0;
      if (cmd.exec) begin
         case (mode_type'(req_ff.mode)) inside
            MODE_ALLOC, MODE_TRY: begin
               if (count_ff != '0) begin
                  rsp_in.handle_out    = ram_rdata;
                  rsp_in.reused        = 1'b1;
                  in_use_in[ram_rdata] = 1'b1;
                  head_in              = head_ff + 1'b1;
                  count_in             = count_ff - 1'b1;
               end else if (mode_type'(req_ff.mode) == MODE_TRY) begin
                  rsp_in.status = STATUS_NONE_FREE;
               end else if (fresh_ff < CAP_VAL) begin
                  rsp_in.handle_out                 = fresh_ff[HANDLE_W-1:0];
                  in_use_in[fresh_ff[HANDLE_W-1:0]] = 1'b1;
                  fresh_in                          = fresh_ff + 1'b1;
               end else begin
                  rsp_in.status = STATUS_EXHAUSTED;
               end
            end
            MODE_RELEASE: begin
               rsp_in.handle_out = req_ff.handle_in;
               if (in_use_ff[req_ff.handle_in]) begin
                  in_use_in[req_ff.handle_in] = 1'b0;
                  ram_we                      = 1'b1;
                  tail_in                     = tail_ff + 1'b1;
                  count_in                    = count_ff + 1'b1;
               end else begin
                  rsp_in.status = STATUS_NOT_IN_USE;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/fifo_handle_pool_allocator_top.sv -----
// Top level of the handle pool allocator: controller plus datapath.
// Depends on fhpa_pkg, fhpa_ctrl, fhpa_datapath.
//
//   channel   ports                  handshake
//   request   req_data               start & !busy
//   result    rsp_data               rsp_strobe, one cycle, no back-pressure
//
// A new request waits until the last one is executed: accept cycle reads the free-list RAM head
// (registered read), execute cycle updates pointers, bitmap and counter.
// The result strobes in the cycle after execute; the next request may be accepted then.
// Synchronous reset clears pointers, counts and the in-use bitmap flops at once;
// the free-list RAM is not cleared, so there is no clearing pass.
// The result side cannot stall.
module fifo_handle_pool_allocator_top #(
   parameter int POOL_SIZE = fhpa_pkg::POOL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fhpa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fhpa_pkg::rsp_type rsp_data
);
   import fhpa_pkg::*;

   cmd_type cmd;

   fhpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   fhpa_datapath #(
      .POOL_SIZE (POOL_SIZE)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/fhpa_checker.sv -----
// Port-level checker for the handle pool allocator, bound to the top level.
// Depends on fhpa_pkg and fifo_handle_pool_allocator_top_defines.svh.
`include "fifo_handle_pool_allocator_top_defines.svh"

module fhpa_assert_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input fhpa_pkg::rsp_type rsp_data
);
   import fhpa_pkg::*;

   logic reuse_beat;

   assign reuse_beat = rsp_strobe && rsp_data.reused;

   `FHPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   `FHPA_ASSERT_NEXT(a_accept_result, clock, reset, start && !busy, ##1 rsp_strobe)
   `FHPA_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   `FHPA_ASSERT_IMPLY(a_reused_ok, clock, reset, reuse_beat, rsp_data.status == STATUS_OK)

endmodule

bind fifo_handle_pool_allocator_top fhpa_assert_checker u_fhpa_assert_checker (.*);
